// ----- hw/rtl/rapq_pkg.sv -----
`timescale 1ns / 1ps
// package for the range assign / point query tree
// shared constants, action codes, controller states and control structs
package rapq_pkg;

	localparam int DEF_MAX_LEAVES = 4096;
	localparam int IDX_W = 13;
	localparam int TASK_W = 31;
	localparam int OUT_W = 32;
	localparam int SEQ_W = 32;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_ASSIGN = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ASSIGN,
		ST_QUERY
	} state_t;

	typedef struct packed {
		logic cfg_wr;
		logic clr_start;
		logic clr_step;
		logic asg_load;
		logic asg_step;
		logic q_load;
		logic q_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic asg_ok;
		logic asg_done;
		logic q_done;
	} status_t;

endpackage

// ----- hw/rtl/range_assign_point_query_tree.sv -----
`timescale 1ns / 1ps
// top level of the range assign / point query tree
// depends on rapq_pkg, rapq_ctrl and rapq_dp
//
// An item is taken when start is high and busy low. Assigns mark the canonical
// nodes of the range with a value and a sequence number, walking up a
// power-of-two tree from the leaves. A query reads its leaf and each ancestor
// from the node memory, one read a cycle, and keeps the newest mark. The
// result is then registered on held_task with done high for a single cycle;
// the receiver cannot stall it. A clear action, a configuration write and
// reset start a clearing pass over the node memory, during which busy is high.
module range_assign_point_query_tree #(
	parameter int MAX_LEAVES = rapq_pkg::DEF_MAX_LEAVES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [rapq_pkg::IDX_W-1:0]    first_index,
	input  logic [rapq_pkg::IDX_W-1:0]    last_index,
	input  logic [rapq_pkg::TASK_W-1:0]   task_value,
	input  logic [rapq_pkg::IDX_W-1:0]    query_position,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rapq_pkg::IDX_W-1:0]    cfg_data,
	output logic signed [rapq_pkg::OUT_W-1:0] held_task,
	output logic                          done
);
	import rapq_pkg::*;

	cmd_t cmd;
	status_t st;

	rapq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.cfg_valid (cfg_valid),
		.st        (st),
		.cmd       (cmd),
		.busy      (busy),
		.cfg_ready (cfg_ready)
	);

	rapq_dp #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.first_index    (first_index),
		.last_index     (last_index),
		.task_value     (task_value),
		.query_position (query_position),
		.cfg_data       (cfg_data),
		.held_task      (held_task),
		.done           (done)
	);

endmodule

// ----- hw/rtl/rapq_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine of the range assign / point query tree
// depends on rapq_pkg, drives the datapath by command struct
module rapq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	input  logic              cfg_valid,
	input  rapq_pkg::status_t st,
	output rapq_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              cfg_ready
);
	import rapq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE) && !start;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (action)
						ACT_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d = ST_CLEAR;
						end
						ACT_ASSIGN: begin
							if (st.asg_ok) begin
								cmd.asg_load = 1'b1;
								state_d = ST_ASSIGN;
							end
						end
						ACT_QUERY: begin
							cmd.q_load = 1'b1;
							state_d = ST_QUERY;
						end
						default: begin
						end
					endcase
				end else if (cfg_valid) begin
					cmd.cfg_wr = 1'b1;
					cmd.clr_start = 1'b1;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done) state_d = ST_IDLE;
			end
			ST_ASSIGN: begin
				cmd.asg_step = 1'b1;
				if (st.asg_done) state_d = ST_IDLE;
			end
			ST_QUERY: begin
				cmd.q_step = 1'b1;
				if (st.q_done) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/rapq_dp.sv -----
`timescale 1ns / 1ps
// datapath of the range assign / point query tree: node memory, range walk,
// leaf-to-root query walk and result register; depends on rapq_pkg
module rapq_dp #(
	parameter int MAX_LEAVES = rapq_pkg::DEF_MAX_LEAVES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rapq_pkg::cmd_t                cmd,
	output rapq_pkg::status_t             st,
	input  logic [rapq_pkg::IDX_W-1:0]    first_index,
	input  logic [rapq_pkg::IDX_W-1:0]    last_index,
	input  logic [rapq_pkg::TASK_W-1:0]   task_value,
	input  logic [rapq_pkg::IDX_W-1:0]    query_position,
	input  logic [rapq_pkg::IDX_W-1:0]    cfg_data,
	output logic signed [rapq_pkg::OUT_W-1:0] held_task,
	output logic                          done
);
	import rapq_pkg::*;

	localparam int LW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
	localparam int NW = LW + 1;
	localparam int AW = NW + 1;
	localparam int DEPTH = 2 ** NW;
	localparam int EW = SEQ_W + TASK_W;
	localparam logic [AW-1:0] LEAF_BASE = AW'(2 ** LW);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_s1;
	logic rdv_s1;

	logic [IDX_W-1:0] leaf_count_q;
	logic [NW-1:0] clr_cnt_q;
	logic [AW-1:0] l_q, r_q, node_q;
	logic [SEQ_W-1:0] seq_q, best_seq_q;
	logic [TASK_W-1:0] val_q, best_val_q;
	logic done_q;
	logic signed [OUT_W-1:0] held_q;

	logic we;
	logic [NW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [31:0] cfg_ext;
	logic [IDX_W-1:0] cfg_sat;
	logic q_ok;

	always_comb begin
		cfg_ext = {{(32-IDX_W){1'b0}}, cfg_data};
		if (cfg_ext == 32'd0) cfg_sat = IDX_W'(1);
		else if (cfg_ext > 32'(MAX_LEAVES)) cfg_sat = IDX_W'(MAX_LEAVES);
		else cfg_sat = cfg_data;
	end

	assign st.asg_ok = (first_index != '0) && (first_index <= last_index)
		&& (last_index <= leaf_count_q);
	assign q_ok = (query_position != '0) && (query_position <= leaf_count_q);
	assign st.clr_done = (clr_cnt_q == NW'(DEPTH - 1));
	assign st.asg_done = (l_q >= r_q);
	assign st.q_done = (node_q == '0) && !rdv_s1;

	always_comb begin
		we = 1'b0;
		waddr = clr_cnt_q;
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.asg_step && (l_q < r_q)) begin
			if (l_q[0]) begin
				we = 1'b1;
				waddr = l_q[NW-1:0];
				wdata = {seq_q, val_q};
			end else if (r_q[0]) begin
				we = 1'b1;
				waddr = NW'(r_q - AW'(1));
				wdata = {seq_q, val_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[node_q[NW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= IDX_W'(MAX_LEAVES);
			clr_cnt_q <= '0;
			seq_q <= '0;
			l_q <= '0;
			r_q <= '0;
			node_q <= '0;
			rdv_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.cfg_wr) leaf_count_q <= cfg_sat;
			if (cmd.clr_start) begin
				clr_cnt_q <= '0;
				seq_q <= '0;
			end else if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + NW'(1);
			end
			if (cmd.asg_load) begin
				l_q <= AW'(first_index) - AW'(1) + LEAF_BASE;
				r_q <= AW'(last_index) + LEAF_BASE;
				seq_q <= seq_q + SEQ_W'(1);
			end else if (cmd.asg_step && (l_q < r_q)) begin
				if (l_q[0]) begin
					l_q <= l_q + AW'(1);
				end else if (r_q[0]) begin
					r_q <= r_q - AW'(1);
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			if (cmd.q_load) begin
				node_q <= q_ok ? (AW'(query_position) - AW'(1) + LEAF_BASE) : '0;
				rdv_s1 <= 1'b0;
			end else if (cmd.q_step) begin
				rdv_s1 <= (node_q != '0);
				if (node_q != '0) node_q <= node_q >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.asg_load) val_q <= task_value;
		if (cmd.q_load) begin
			best_seq_q <= '0;
			best_val_q <= '0;
		end else if (cmd.q_step && rdv_s1 && (rd_s1[EW-1:TASK_W] > best_seq_q)) begin
			best_seq_q <= rd_s1[EW-1:TASK_W];
			best_val_q <= rd_s1[TASK_W-1:0];
		end
		if (cmd.emit) held_q <= (best_seq_q == '0) ? '1 : $signed({1'b0, best_val_q});
	end

	assign held_task = held_q;
	assign done = done_q;

endmodule

// ----- verif/range_assign_point_query_tree_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for range_assign_point_query_tree
// depends on rapq_pkg and the rtl; predicts each query from a flat per-position task map
module range_assign_point_query_tree_tb;
	import rapq_pkg::*;

	localparam int MAXL = DEF_MAX_LEAVES;
	localparam int SETTLE = 80;
	localparam int WD_LIMIT = 40000;
	localparam logic [OUT_W-1:0] NONE = '1;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct {
		logic [1:0] act;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [TASK_W-1:0] val;
		logic [IDX_W-1:0] pos;
		bit typed;
		logic [OUT_W-1:0] held;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] action;
	logic [IDX_W-1:0] first_index;
	logic [IDX_W-1:0] last_index;
	logic [TASK_W-1:0] task_value;
	logic [IDX_W-1:0] query_position;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_data;
	logic signed [OUT_W-1:0] held_task;
	logic done;

	logic [OUT_W-1:0] pos_task [1:MAXL];
	int unsigned leaves;
	logic [OUT_W-1:0] held_due [$];
	int errors;
	int n_items, n_queries, n_assigns, n_clears, n_cfg;
	int wd_count;

	range_assign_point_query_tree u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .first_index(first_index), .last_index(last_index),
		.task_value(task_value), .query_position(query_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.held_task(held_task), .done(done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
		$display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	function automatic void wipe_tasks();
		for (int i = 1; i <= MAXL; i++)
			pos_task[i] = NONE;
	endfunction

	// apply one accepted item to the map, return 1 when a result is due
	function automatic bit predict_item(row_t r, output logic [OUT_W-1:0] held);
		held = NONE;
		case (r.act)
			ACT_CLEAR: wipe_tasks();
			ACT_ASSIGN: begin
				if (r.lo >= 1 && r.lo <= r.hi && r.hi <= leaves)
					for (int i = int'(r.lo); i <= int'(r.hi); i++)
						pos_task[i] = {1'b0, r.val};
			end
			ACT_QUERY: begin
				if (r.pos >= 1 && r.pos <= leaves)
					held = pos_task[r.pos];
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send_item(row_t r);
		bit ok;
		logic [OUT_W-1:0] held;
		action <= r.act;
		first_index <= r.lo;
		last_index <= r.hi;
		task_value <= r.val;
		query_position <= r.pos;
		start <= 1'b1;
		do begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end while (!ok);
		if (predict_item(r, held))
			held_due.push_back(r.typed ? r.held : held);
		n_items++;
		if (r.act == ACT_QUERY) n_queries++;
		if (r.act == ACT_ASSIGN) n_assigns++;
		if (r.act == ACT_CLEAR) n_clears++;
	endtask

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (held_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_leaves(logic [IDX_W-1:0] v);
		bit ok;
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		leaves = (v < 1) ? 1 : (v > MAXL) ? MAXL : v;
		wipe_tasks();
		n_cfg++;
	endtask

	function automatic row_t mk(logic [1:0] a, int lo, int hi, logic [TASK_W-1:0] v, int p,
			bit typed = 0, logic [OUT_W-1:0] held = NONE);
		row_t r;
		r.act = a; r.lo = IDX_W'(lo); r.hi = IDX_W'(hi); r.val = v; r.pos = IDX_W'(p);
		r.typed = typed; r.held = held;
		return r;
	endfunction

	function automatic row_t rand_row();
		row_t r;
		int k;
		int span;
		int top;
		r.typed = 0; r.held = NONE;
		r.lo = IDX_W'($urandom); r.hi = IDX_W'($urandom); r.pos = IDX_W'($urandom);
		k = $urandom_range(0, 99);
		case ($urandom_range(0, 5))
			0: r.val = '0;
			1: r.val = '1;
			default: r.val = TASK_W'($urandom);
		endcase
		if (k < 46) begin
			r.act = ACT_ASSIGN;
			r.lo = IDX_W'($urandom_range(1, leaves));
			span = ($urandom_range(0, 3) == 0) ? int'(leaves) : 16;
			top = (int'(r.lo) + span > int'(leaves)) ? int'(leaves) : int'(r.lo) + span;
			r.hi = IDX_W'($urandom_range(int'(r.lo), top));
		end else if (k < 88) begin
			r.act = ACT_QUERY;
			r.pos = IDX_W'($urandom_range(1, leaves));
		end else if (k < 90) begin
			r.act = ACT_CLEAR;
		end else begin
			r.act = 2'($urandom);
			if ($urandom_range(0, 1)) begin
				r.pos = IDX_W'(leaves + $urandom_range(1, 3));
				r.hi = IDX_W'(leaves + $urandom_range(0, 1));
			end
		end
		return r;
	endfunction

	task automatic random_phase(int count);
		int burst;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 20));
				burst = $urandom_range(1, 30);
			end
			burst--;
			send_item(rand_row());
			if (i == count / 2) drain();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (held_due.size() == 0) begin
				report_mismatch("unexpected held_task", NONE, held_task);
			end else begin
				if (held_task !== held_due[0])
					report_mismatch("held_task", held_due[0], held_task);
				void'(held_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			wd_count <= 0;
		else if (wd_count >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			wd_count <= wd_count + 1;
	end

	initial begin
		row_t plan [$];
		logic [IDX_W-1:0] sizes [$];
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_CLEAR;
		first_index = '0;
		last_index = '0;
		task_value = '0;
		query_position = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		leaves = MAXL;
		wipe_tasks();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			mk(ACT_QUERY, 0, 0, 0, 1, 1, NONE),
			mk(ACT_QUERY, 0, 0, 0, MAXL, 1, NONE),
			mk(ACT_QUERY, 0, 0, 0, 0, 1, NONE),
			mk(ACT_QUERY, 0, 0, 0, MAXL + 1, 1, NONE),
			mk(ACT_QUERY, 8191, 8191, '1, 8191, 1, NONE),
			mk(ACT_ASSIGN, 1, MAXL, '1, 0),
			mk(ACT_QUERY, 0, 0, 0, MAXL),
			mk(ACT_QUERY, 0, 0, 0, 1),
			mk(ACT_ASSIGN, 1, 1, 0, 0),
			mk(ACT_QUERY, 0, 0, 0, 1),
			mk(ACT_ASSIGN, MAXL, MAXL, 5, 0),
			mk(ACT_QUERY, 0, 0, 0, MAXL),
			mk(ACT_ASSIGN, 0, 10, 77, 0),
			mk(ACT_ASSIGN, 20, 10, 78, 0),
			mk(ACT_ASSIGN, 10, MAXL + 1, 79, 0),
			mk(ACT_ASSIGN, 8191, 8191, 80, 0),
			mk(ACT_SPARE, 1, MAXL, 81, 5),
			mk(ACT_QUERY, 0, 0, 0, 10),
			mk(ACT_ASSIGN, 2047, 2050, 12345, 0),
			mk(ACT_QUERY, 0, 0, 0, 2048),
			mk(ACT_QUERY, 0, 0, 0, 2051),
			mk(ACT_CLEAR, 8191, 8191, '1, 8191),
			mk(ACT_QUERY, 0, 0, 0, 2, 1, NONE),
			mk(ACT_QUERY, 0, 0, 0, MAXL, 1, NONE)
		};
		foreach (plan[i]) send_item(plan[i]);
		random_phase(200);

		sizes = '{1, 0, 2, 8191, 13, 4097, 300, 4096};
		foreach (sizes[i]) begin
			write_leaves(sizes[i]);
			random_phase(190);
		end

		drain();
		$display("covered %0d items: %0d queries, %0d assigns, %0d clears", n_items, n_queries,
			n_assigns, n_clears);
		$display("leaf_count written %0d times incl. 0, 1, 4096 and 8191", n_cfg);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
